// File: design/tkht_pkg.sv
// ----------------------------------------------------------------------------
// tkht_pkg: shared types for the two-key hash table
// Request and response payloads and the operation codes.
// ----------------------------------------------------------------------------
package tkht_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] key_first;
		logic [63:0] key_second;
		logic [63:0] value_in;
	} req_t;

	typedef struct packed {
		logic [63:0] value_out;
		logic        hit;
		logic        status;
	} rsp_t;

endpackage

// File: design/two_key_hash_table_core.sv
// ----------------------------------------------------------------------------
// two_key_hash_table_core: map keyed by a pair of 64-bit keys
// A request (insert, lookup or remove) is taken when start is high and busy
// is low. Its single response appears on rsp, with done high for exactly one
// cycle; the receiver cannot stall it. The bucket is the low log2(BUCKETS) bits
// of ((key_first << SHIFT) + key_second), so BUCKETS must be a power of two,
// and each bucket has WAYS slots held in single-port synchronous memories.
// One transaction keeps busy high through one bucket-base state, a read and a
// compare state per way and one write-back state, and the response is on rsp
// in the first cycle with busy low.
// After reset the used flags are swept clear, one slot per cycle, holding busy
// high until every slot is clear.
// ----------------------------------------------------------------------------
module two_key_hash_table_core #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4,
	parameter int SHIFT   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tkht_pkg::req_t  req,
	output logic            done,
	output tkht_pkg::rsp_t  rsp
);

	localparam int  SLOTS   = BUCKETS * WAYS;
	localparam int  BW      = $clog2(BUCKETS);
	localparam int  SW      = $clog2(SLOTS);
	localparam int  WW      = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_BASE  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t          state_q;
	tkht_pkg::req_t  req_q;
	logic [BW-1:0]   rem_q;
	logic [SW-1:0]   base_q;
	logic [SW-1:0]   clr_cnt_q;
	logic [WW-1:0]   way_q;
	logic            found_q;
	logic            free_q;
	logic [WW-1:0]   match_way_q;
	logic [WW-1:0]   free_way_q;
	logic [63:0]     match_val_q;
	logic            done_q;
	tkht_pkg::rsp_t  rsp_q;

	logic            used_mem_q [SLOTS];
	logic [63:0]     key1_mem_q [SLOTS];
	logic [63:0]     key2_mem_q [SLOTS];
	logic [63:0]     val_mem_q  [SLOTS];

	logic            used_rd_q;
	logic [63:0]     key1_rd_q;
	logic [63:0]     key2_rd_q;
	logic [63:0]     val_rd_q;

	logic [BW-1:0]   rem_d;
	logic [SW-1:0]   rd_addr;
	logic            cmp_match;
	logic            last_way;
	logic            accept;

	logic            used_we;
	logic            used_wd;
	logic            key_we;
	logic            val_we;
	logic [SW-1:0]   wr_addr;
	tkht_pkg::rsp_t  rsp_d;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign rem_d     = BW'((req.key_first << SHIFT) + req.key_second);
	assign rd_addr   = base_q + SW'(way_q);
	assign last_way  = (way_q == WW'(WAYS - 1));
	assign cmp_match = used_rd_q && (key1_rd_q == req_q.key_first)
	                   && (key2_rd_q == req_q.key_second);

	// write-back decision and the used-flag sweep after reset
	always_comb begin
		used_we = 1'b0;
		used_wd = 1'b0;
		key_we  = 1'b0;
		val_we  = 1'b0;
		wr_addr = base_q + SW'(match_way_q);
		rsp_d   = '0;
		if (state_q == ST_CLEAR) begin
			used_we = 1'b1;
			wr_addr = clr_cnt_q;
		end else if (state_q == ST_WRITE) begin
			unique case (req_q.opcode)
				tkht_pkg::OP_INSERT: begin
					if (found_q) begin
						val_we          = 1'b1;
						rsp_d.value_out = match_val_q;
						rsp_d.hit       = 1'b1;
					end else if (free_q) begin
						wr_addr = base_q + SW'(free_way_q);
						used_we = 1'b1;
						used_wd = 1'b1;
						key_we  = 1'b1;
						val_we  = 1'b1;
					end else begin
						rsp_d.status = 1'b1;
					end
				end
				tkht_pkg::OP_LOOKUP: begin
					if (found_q) begin
						rsp_d.value_out = match_val_q;
						rsp_d.hit       = 1'b1;
					end
				end
				tkht_pkg::OP_REMOVE: begin
					if (found_q) begin
						used_we         = 1'b1;
						rsp_d.value_out = match_val_q;
						rsp_d.hit       = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem_q[wr_addr] <= used_wd;
		end
		if (key_we) begin
			key1_mem_q[wr_addr] <= req_q.key_first;
			key2_mem_q[wr_addr] <= req_q.key_second;
		end
		if (val_we) begin
			val_mem_q[wr_addr] <= req_q.value_in;
		end
		if (state_q == ST_READ) begin
			used_rd_q <= used_mem_q[rd_addr];
			key1_rd_q <= key1_mem_q[rd_addr];
			key2_rd_q <= key2_mem_q[rd_addr];
			val_rd_q  <= val_mem_q[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			rem_q <= rem_d;
		end
		if (state_q == ST_BASE) begin
			base_q <= SW'(SW'(rem_q) * SW'(WAYS));
		end
		if (state_q == ST_CMP) begin
			if (cmp_match && !found_q) begin
				match_way_q <= way_q;
				match_val_q <= val_rd_q;
			end
			if (!used_rd_q && !free_q) begin
				free_way_q <= way_q;
			end
		end
		if (state_q == ST_WRITE) begin
			rsp_q <= rsp_d;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			way_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + SW'(1);
					if (clr_cnt_q == SW'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						way_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmp_match) begin
						found_q <= 1'b1;
					end
					if (!used_rd_q) begin
						free_q <= 1'b1;
					end
					if (last_way) begin
						state_q <= ST_WRITE;
					end else begin
						way_q   <= way_q + WW'(1);
						state_q <= ST_READ;
					end
				end
				ST_WRITE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_WRITE))
		else $error("response without write-back");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response strobe longer than one cycle");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |-> (!rsp.hit && (rsp.value_out == '0)))
		else $error("full bucket response carries data");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !done)
		else $error("response during clearing pass");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for two_key_hash_table_core
// A directed table covers the reset state, the key extremes, replacement,
// full buckets, wrap of the bucket sum and the unused opcode. Random traffic
// follows, mostly aimed at a few crowded buckets, so that buckets fill, drain
// and refill. Each response is compared with the table row or a software map.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUCKETS = 1024;
	localparam int WAYS = 4;
	localparam int SHIFT = 8;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1530;
	localparam int CALM_TAIL = 150;
	localparam int HOT = 6;
	localparam int POOL_PER = 7;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 4 * (2 + 2 * WAYS);
	localparam logic [63:0] ONES = '1;
	localparam logic [63:0] V2 = 64'h0123_4567_89ab_cdef;

	typedef struct {
		tkht_pkg::req_t r;
		bit             typed;
		tkht_pkg::rsp_t e;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	tkht_pkg::req_t req = '0;
	logic busy;
	logic done;
	tkht_pkg::rsp_t rsp;

	bit          map_used [SLOTS];
	logic [63:0] map_k1 [SLOTS];
	logic [63:0] map_k2 [SLOTS];
	logic [63:0] map_val [SLOTS];

	tkht_pkg::rsp_t pending_rsp [$];
	dir_row_t       dir_rows [$];
	int             errors = 0;
	int             idle_cycles = 0;

	logic [63:0] pool_k1 [HOT * POOL_PER];
	logic [63:0] pool_k2 [HOT * POOL_PER];

	two_key_hash_table_core #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS),
		.SHIFT  (SHIFT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int bucket_of(logic [63:0] k1, logic [63:0] k2);
		logic [63:0] s;
		s = (k1 << SHIFT) + k2;
		return int'(s % 64'(BUCKETS));
	endfunction

	// software map: applies one request and returns its response
	function automatic tkht_pkg::rsp_t apply_to_map(tkht_pkg::req_t r);
		tkht_pkg::rsp_t o;
		int   base;
		int   idx;
		bit   found;
		bit   have_free;
		int   match_idx;
		int   free_idx;
		o = '0;
		base = bucket_of(r.key_first, r.key_second) * WAYS;
		found = 1'b0;
		have_free = 1'b0;
		match_idx = 0;
		free_idx = 0;
		for (int w = 0; w < WAYS; w++) begin
			idx = base + w;
			if (map_used[idx]) begin
				if (!found && map_k1[idx] == r.key_first && map_k2[idx] == r.key_second) begin
					found = 1'b1;
					match_idx = idx;
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_idx = idx;
			end
		end
		unique case (r.opcode)
			tkht_pkg::OP_INSERT: begin
				if (found) begin
					o.value_out = map_val[match_idx];
					o.hit = 1'b1;
					map_val[match_idx] = r.value_in;
				end else if (have_free) begin
					map_used[free_idx] = 1'b1;
					map_k1[free_idx] = r.key_first;
					map_k2[free_idx] = r.key_second;
					map_val[free_idx] = r.value_in;
				end else begin
					o.status = 1'b1;
				end
			end
			tkht_pkg::OP_LOOKUP: begin
				if (found) begin
					o.value_out = map_val[match_idx];
					o.hit = 1'b1;
				end
			end
			tkht_pkg::OP_REMOVE: begin
				if (found) begin
					o.value_out = map_val[match_idx];
					o.hit = 1'b1;
					map_used[match_idx] = 1'b0;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic void add_row(logic [1:0] op, logic [63:0] k1, logic [63:0] k2,
			logic [63:0] v, bit typed, logic [63:0] ev, logic eh, logic es);
		dir_row_t d;
		d.r = '{opcode: op, key_first: k1, key_second: k2, value_in: v};
		d.typed = typed;
		d.e = '{value_out: ev, hit: eh, status: es};
		dir_rows.push_back(d);
	endfunction

	// drive one transaction and wait until it is taken
	task automatic send(tkht_pkg::req_t r, bit typed, tkht_pkg::rsp_t e);
		tkht_pkg::rsp_t p;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		p = apply_to_map(r);
		pending_rsp.push_back(typed ? e : p);
	endtask

	task automatic pause(int gap);
		start <= 1'b0;
		if ($urandom_range(0, 1))
			while (busy) @(posedge clk);
		repeat (gap) @(posedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		tkht_pkg::rsp_t exp_rsp;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response: value_out %h hit %b status %b",
					rsp.value_out, rsp.hit, rsp.status);
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.value_out !== exp_rsp.value_out) begin
					$error("value_out: expected %h, actual %h", exp_rsp.value_out, rsp.value_out);
					errors++;
				end
				if (rsp.hit !== exp_rsp.hit) begin
					$error("hit: expected %b, actual %b", exp_rsp.hit, rsp.hit);
					errors++;
				end
				if (rsp.status !== exp_rsp.status) begin
					$error("status: expected %b, actual %b", exp_rsp.status, rsp.status);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction in either direction
	always @(posedge clk) begin
		if ((start && !busy && arst_n) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		tkht_pkg::req_t r;
		tkht_pkg::rsp_t none;
		int          pick;
		int          sel;
		int          hb;
		int          gappy;
		logic [63:0] base_k2;
		none = '0;

		for (int i = 0; i < SLOTS; i++)
			map_used[i] = 1'b0;

		for (int h = 0; h < HOT; h++) begin
			hb = $urandom_range(0, BUCKETS - 1);
			for (int j = 0; j < POOL_PER; j++) begin
				pool_k1[h * POOL_PER + j] = rand64();
				base_k2 = rand64();
				base_k2 = base_k2 - (base_k2 % 64'(BUCKETS)) + 64'(hb);
				pool_k2[h * POOL_PER + j] = base_k2 - (pool_k1[h * POOL_PER + j] << SHIFT);
			end
		end

		add_row(tkht_pkg::OP_LOOKUP, 64'd0, 64'd0, ONES, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_REMOVE, ONES, ONES, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd0, ONES, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_LOOKUP, 64'd0, 64'd0, 64'd0, 1'b1, ONES, 1'b1, 1'b0);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd0, V2, 1'b1, ONES, 1'b1, 1'b0);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd1024, 64'd1, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd2048, 64'd2, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd3072, 64'd3, 1'b1, 64'd0, 1'b0, 1'b0);
		// bucket 0 full
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd4096, 64'd4, 1'b1, 64'd0, 1'b0, 1'b1);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd0, 64'd5, 1'b1, V2, 1'b1, 1'b0);
		add_row(tkht_pkg::OP_REMOVE, 64'd0, 64'd1024, 64'd0, 1'b1, 64'd1, 1'b1, 1'b0);
		add_row(tkht_pkg::OP_LOOKUP, 64'd0, 64'd1024, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_REMOVE, 64'd0, 64'd0, 64'd0, 1'b1, 64'd5, 1'b1, 1'b0);
		// match in way 2 wins over the free way 0
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd2048, 64'd6, 1'b1, 64'd2, 1'b1, 1'b0);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd4096, ONES, 1'b0, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_INSERT, 64'd0, 64'd8192, 64'd7, 1'b1, 64'd0, 1'b0, 1'b0);
		// bucket sum wraps to bucket 0, which is full again
		add_row(tkht_pkg::OP_INSERT, ONES, 64'h100, 64'd0, 1'b1, 64'd0, 1'b0, 1'b1);
		add_row(OP_UNUSED, ONES, ONES, ONES, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_INSERT, ONES, ONES, ONES, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_LOOKUP, ONES, ONES, 64'd0, 1'b1, ONES, 1'b1, 1'b0);
		add_row(tkht_pkg::OP_LOOKUP, ONES, ONES ^ 64'd1024, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_LOOKUP, ONES ^ (64'd1 << 63), ONES, 64'd0, 1'b1, 64'd0,
			1'b0, 1'b0);
		add_row(tkht_pkg::OP_LOOKUP, 64'd0, 64'd4096, 64'd0, 1'b0, 64'd0, 1'b0, 1'b0);
		add_row(tkht_pkg::OP_REMOVE, ONES, ONES, 64'd0, 1'b1, ONES, 1'b1, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
			if ($urandom_range(0, 2) == 0)
				pause($urandom_range(1, 8));
		end

		gappy = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				gappy = $urandom_range(0, 1);
			pick = $urandom_range(0, 99);
			r.value_in = rand64();
			if (pick < 80) begin
				sel = $urandom_range(0, HOT * POOL_PER - 1);
				r.key_first = pool_k1[sel];
				r.key_second = pool_k2[sel];
				pick = $urandom_range(0, 99);
				r.opcode = pick < 45 ? tkht_pkg::OP_INSERT :
					(pick < 75 ? tkht_pkg::OP_LOOKUP : tkht_pkg::OP_REMOVE);
			end else if (pick < 92) begin
				r.key_first = rand64();
				r.key_second = rand64();
				r.opcode = 2'($urandom_range(0, 2));
			end else if (pick < 97) begin
				// same bucket as a pool pair, one key differs
				sel = $urandom_range(0, HOT * POOL_PER - 1);
				r.key_first = pool_k1[sel];
				r.key_second = pool_k2[sel];
				if ($urandom_range(0, 1))
					r.key_first = r.key_first ^ (64'd1 << 63);
				else
					r.key_second = r.key_second + 64'(BUCKETS) * 64'($urandom_range(1, 255));
				r.opcode = 2'($urandom_range(0, 2));
			end else begin
				r.key_first = rand64();
				r.key_second = rand64();
				r.opcode = OP_UNUSED;
			end
			send(r, 1'b0, none);
			if (n < RANDOM_ITEMS - CALM_TAIL && gappy != 0 && $urandom_range(0, 2) == 0)
				pause($urandom_range(1, 8));
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
